// ===== rtl/hill_cipher_2x2_mod26_macros.svh =====
// Assertion macros shared by the block
`ifndef HILL_CIPHER_2X2_MOD26_MACROS_SVH
`define HILL_CIPHER_2X2_MOD26_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hc assertion failed");

// Next-cycle implication, disabled during reset
`define HC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hc assertion failed");

`endif

// ===== rtl/hc_pkg.sv =====
package hc_pkg;

  localparam int unsigned LetterW    = 5;
  localparam int unsigned Modulus    = 26;
  localparam int unsigned PadLetter  = 23;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 5;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_K00    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_K01    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_K10    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_K11    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DECRYPT = 3'd4;

  typedef logic [LetterW-1:0] letter_t;

  typedef struct packed {
    logic [4:0] letter_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [4:0] out_letter;
    logic       last_out;
    logic       key_not_invertible;
  } out_item_t;

  // one completed pair, already reduced mod 26
  typedef struct packed {
    letter_t p0;
    letter_t p1;
    logic    last;
  } pair_t;

  // working matrix handed to the back end
  typedef struct packed {
    letter_t m00;
    letter_t m01;
    letter_t m10;
    letter_t m11;
    logic    bad;
    logic    ready;
  } key_mat_t;

  // fold 26..31 into 0..5
  function automatic letter_t red26(input letter_t v);
    return (v >= letter_t'(Modulus)) ? letter_t'(v - letter_t'(Modulus)) : v;
  endfunction

  // x mod 26 for x < 2048: reciprocal estimate, then one correction
  function automatic letter_t mod26(input logic [10:0] x);
    logic [17:0]        prod;
    logic [6:0]         q;
    logic signed [11:0] r;
    prod = 18'(x) * 18'd79;
    q    = prod[17:11];
    r    = $signed({1'b0, x}) - $signed(12'((q << 4) + (q << 3) + (q << 1)));
    if (r < 0) r = r + 12'sd26;
    return r[LetterW-1:0];
  endfunction

  // multiplicative inverse mod 26, zero where none exists
  function automatic letter_t inv26(input letter_t v);
    letter_t r;
    case (v)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/hill_cipher_2x2_mod26.sv =====
// 2x2 Hill cipher, mod 26. Letters enter on the in channel, one transfer per
// cycle while the pair queue has room; the front pairs them (an unpaired
// final letter is padded with X) and the back multiplies each pair by the key
// or its inverse and sends two letters, the last one marked. The back's
// sequencer steps through one multiply, one reduce and two sends per pair
// and takes no new pair until both letters are sent; output stalls hold it
// in the sends. After a configuration write, or after reset, the derived
// matrix must settle through the derivation pipeline, during which no pair
// is processed. In decrypt mode a key with no inverse mod 26 yields letters
// of 0 with key_not_invertible set.
module hill_cipher_2x2_mod26 #(
  parameter int unsigned QUEUE_DEPTH = hc_pkg::QueueDepth
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  hc_pkg::in_item_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output hc_pkg::out_item_t           out_data,
  input  logic                        cfg_write,
  input  logic [hc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [hc_pkg::CfgDataW-1:0] cfg_data
);
  import hc_pkg::*;
  `include "hill_cipher_2x2_mod26_macros.svh"

  key_mat_t key;
  pair_t    push_data, head;
  logic     push, pop, empty, full;

  hc_keygen u_keygen (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  hc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  hc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  hc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .key       (key),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // checks
  `HC_ASSERT_NOW(a_pop_needs_key, pop, key.ready && !empty)
  `HC_ASSERT_NEXT(a_write_resettles, cfg_write, !key.ready)
  `HC_ASSERT_NOW(a_bad_key_zero, out_valid && out_data.key_not_invertible,
    out_data.out_letter == 5'd0)

endmodule

// ===== rtl/hc_keygen.sv =====
module hc_keygen (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [hc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [hc_pkg::CfgDataW-1:0] cfg_data,
  output hc_pkg::key_mat_t           key
);
  import hc_pkg::*;

  localparam logic [1:0] SETTLE = 2'd3;

  letter_t    k00, k01, k10, k11;
  logic       decrypt_mode;
  logic [1:0] settle;

  // stage 1: reduced keys and determinant products
  letter_t    a1, b1, c1, d1;
  logic [9:0] ad1, bc1;
  logic       dec1;
  // stage 2: determinant inverse
  letter_t    a2, b2, c2, d2, di2;
  logic       dec2;
  // stage 3: working matrix
  letter_t    m00, m01, m10, m11;
  logic       bad;

  letter_t    ra, rb, rc, rd;
  letter_t    det;
  letter_t    nb, nc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k00          <= 5'd1;
      k01          <= 5'd0;
      k10          <= 5'd0;
      k11          <= 5'd1;
      decrypt_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_K00:     k00 <= cfg_data[LetterW-1:0];
        REG_K01:     k01 <= cfg_data[LetterW-1:0];
        REG_K10:     k10 <= cfg_data[LetterW-1:0];
        REG_K11:     k11 <= cfg_data[LetterW-1:0];
        REG_DECRYPT: decrypt_mode <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // matrix is stale until the derivation pipeline refills
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      settle <= SETTLE;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  assign ra = red26(k00);
  assign rb = red26(k01);
  assign rc = red26(k10);
  assign rd = red26(k11);

  always_ff @(posedge clk) begin
    a1   <= ra;
    b1   <= rb;
    c1   <= rc;
    d1   <= rd;
    ad1  <= 10'(ra) * 10'(rd);
    bc1  <= 10'(rb) * 10'(rc);
    dec1 <= decrypt_mode;
  end

  assign det = mod26(11'(ad1) + 11'(Modulus * Modulus) - 11'(bc1));

  always_ff @(posedge clk) begin
    a2   <= a1;
    b2   <= b1;
    c2   <= c1;
    d2   <= d1;
    di2  <= inv26(det);
    dec2 <= dec1;
  end

  // negated off-diagonal entries
  assign nb = (b2 == 5'd0) ? 5'd0 : letter_t'(5'(Modulus) - b2);
  assign nc = (c2 == 5'd0) ? 5'd0 : letter_t'(5'(Modulus) - c2);

  // stage 3: final matrix
  always_ff @(posedge clk) begin
    if (dec2) begin
      m00 <= mod26(11'(10'(d2) * 10'(di2)));
      m01 <= mod26(11'(10'(nb) * 10'(di2)));
      m10 <= mod26(11'(10'(nc) * 10'(di2)));
      m11 <= mod26(11'(10'(a2) * 10'(di2)));
      bad <= (di2 == 5'd0);
    end else begin
      m00 <= a2;
      m01 <= b2;
      m10 <= c2;
      m11 <= d2;
      bad <= 1'b0;
    end
  end

  assign key = '{m00: m00, m01: m01, m10: m10, m11: m11, bad: bad,
                 ready: (settle == 2'd0)};

endmodule

// ===== rtl/hc_front.sv =====
module hc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  hc_pkg::in_item_t in_data,
  output logic             push,
  output hc_pkg::pair_t    push_data,
  input  logic             full
);
  import hc_pkg::*;

  letter_t held_letter;
  logic    holding_first;
  letter_t letter;
  logic    take;

  assign in_stall = full;
  assign take     = in_valid && !in_stall;
  assign letter   = red26(in_data.letter_code);

  // a pair is complete on a second letter or on an unpaired end mark
  assign push = take && (holding_first || in_data.end_of_text);

  always_comb begin
    if (holding_first) begin
      push_data.p0 = held_letter;
      push_data.p1 = letter;
    end else begin
      push_data.p0 = letter;
      push_data.p1 = letter_t'(PadLetter);
    end
    push_data.last = in_data.end_of_text;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holding_first <= 1'b0;
    end else if (take) begin
      holding_first <= !holding_first && !in_data.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !holding_first) held_letter <= letter;
  end

endmodule

// ===== rtl/hc_fifo.sv =====
module hc_fifo #(
  parameter int unsigned DEPTH = hc_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hc_pkg::pair_t push_data,
  input  logic          pop,
  output hc_pkg::pair_t head,
  output logic          empty,
  output logic          full
);
  import hc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  pair_t            entries [DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count;

  assign empty = (count == CntW'(0));
  assign full  = (count == CntW'(DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      if (push && !pop)      count <= count + CntW'(1);
      else if (pop && !push) count <= count - CntW'(1);
    end
  end

endmodule

// ===== rtl/hc_back.sv =====
module hc_back (
  input  logic              clk,
  input  logic              rst,
  input  hc_pkg::key_mat_t  key,
  input  hc_pkg::pair_t     head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output hc_pkg::out_item_t out_data
);
  import hc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_SEND0 = 2'd2;
  localparam logic [1:0] ST_SEND1 = 2'd3;

  logic [1:0] state, state_next;
  logic [9:0] pr00, pr01, pr10, pr11;
  logic       bad, last;
  letter_t    r0, r1;
  logic       sent;

  assign pop  = (state == ST_IDLE) && !empty && key.ready;
  assign sent = out_valid && !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (pop) state_next = ST_MUL;
      ST_MUL:   state_next = ST_SEND0;
      ST_SEND0: if (sent) state_next = ST_SEND1;
      ST_SEND1: if (sent) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // products of the matrix and the popped pair
  always_ff @(posedge clk) begin
    if (pop) begin
      pr00 <= 10'(key.m00) * 10'(head.p0);
      pr01 <= 10'(key.m01) * 10'(head.p1);
      pr10 <= 10'(key.m10) * 10'(head.p0);
      pr11 <= 10'(key.m11) * 10'(head.p1);
      bad  <= key.bad;
      last <= head.last;
    end
  end

  // reduce the sums; a non-invertible key forces zero letters
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      r0 <= bad ? 5'd0 : mod26(11'(pr00) + 11'(pr01));
      r1 <= bad ? 5'd0 : mod26(11'(pr10) + 11'(pr11));
    end
  end

  assign out_valid                   = (state == ST_SEND0) || (state == ST_SEND1);
  assign out_data.out_letter         = (state == ST_SEND1) ? r1 : r0;
  assign out_data.last_out           = (state == ST_SEND1) && last;
  assign out_data.key_not_invertible = bad;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import hc_pkg::*;

  localparam int SETTLE_CYCLES = 12;    // margin for the back end to finish and the matrix to settle
  localparam int LONG_HOLD     = 120;   // receiver hold-off that fills the pair queue
  localparam int QUIET_LIMIT   = 1000;  // cycles without any transfer before giving up
  localparam int CHUNK_LETTERS = 50;
  localparam int NUM_ROWS      = 42;

  // register indexes the block does not decode
  localparam logic [CfgIdxW-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_UNUSED_HI = 3'd7;

  typedef enum logic {ROW_LETTER, ROW_WRITE} row_kind_t;

  // one line of the directed script: a letter transfer or a register write
  typedef struct packed {
    row_kind_t          kind;
    logic [4:0]         letter;
    logic               eot;
    logic [CfgIdxW-1:0] idx;
    logic [4:0]         val;
    logic               typed;   // results below are known by hand
    out_item_t          r0;
    out_item_t          r1;
  } row_t;

  localparam out_item_t NO_RES = '0;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  hill_cipher_2x2_mod26 i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // cipher state mirrored from the block
  logic [4:0] key_a, key_b, key_c, key_d;
  bit decrypting;
  logic [4:0] held_first;
  bit have_first;

  out_item_t pending_letters[$];
  int error_count = 0;
  int quiet_cycles = 0;
  bit moved;
  out_item_t want0, want1, got;

  // driver-owned: hand-written results for the next letter transfer
  bit typed_on = 1'b0;
  out_item_t typed_r0, typed_r1;

  int send_idle_pct = 15;
  int recv_idle_pct = 56;
  bit want_hold = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;

  row_t script [NUM_ROWS];

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("mismatch on %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $time);
    error_count++;
  endtask

  // append one expected result letter at the tail of the queue
  task automatic expect_letter(input out_item_t item);
    pending_letters.insert(pending_letters.size(), item);
  endtask

  // one pair through the key (or its inverse), two result letters
  task automatic cipher_pair(input int p0, input int p1, input bit last,
                             output out_item_t r0, output out_item_t r1);
    int a, b, c, d, m00, m01, m10, m11, det, dinv, k;
    bit bad;
    a = key_a % Modulus;
    b = key_b % Modulus;
    c = key_c % Modulus;
    d = key_d % Modulus;
    m00 = a;
    m01 = b;
    m10 = c;
    m11 = d;
    bad = 1'b0;
    if (decrypting) begin
      det = (a * d + Modulus * Modulus - b * c) % Modulus;
      dinv = 0;
      for (k = 1; k < Modulus; k++) begin
        if ((det * k) % Modulus == 1) dinv = k;
      end
      if (dinv == 0) begin
        bad = 1'b1;
      end else begin
        // adjugate scaled by the inverse determinant
        m00 = (d * dinv) % Modulus;
        m01 = ((Modulus - b) * dinv) % Modulus;
        m10 = ((Modulus - c) * dinv) % Modulus;
        m11 = (a * dinv) % Modulus;
      end
    end
    p0 = p0 % Modulus;
    p1 = p1 % Modulus;
    r0.out_letter = bad ? 5'd0 : 5'((m00 * p0 + m01 * p1) % Modulus);
    r0.last_out = 1'b0;
    r0.key_not_invertible = bad;
    r1.out_letter = bad ? 5'd0 : 5'((m10 * p0 + m11 * p1) % Modulus);
    r1.last_out = last;
    r1.key_not_invertible = bad;
  endtask

  // monitor: mirror register writes, predict on input transfers, check outputs
  always @(posedge clk) begin
    if (rst) begin
      key_a = 5'd1;
      key_b = 5'd0;
      key_c = 5'd0;
      key_d = 5'd1;
      decrypting = 1'b0;
      held_first = '0;
      have_first = 1'b0;
      quiet_cycles = 0;
    end else begin
      moved = cfg_write;
      if (cfg_write) begin
        case (cfg_index)
          REG_K00:     key_a = cfg_data;
          REG_K01:     key_b = cfg_data;
          REG_K10:     key_c = cfg_data;
          REG_K11:     key_d = cfg_data;
          REG_DECRYPT: decrypting = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        if (have_first || in_data.end_of_text) begin
          if (have_first) begin
            cipher_pair(held_first, in_data.letter_code, in_data.end_of_text, want0, want1);
          end else begin
            // odd message: pad with X
            cipher_pair(in_data.letter_code, PadLetter, 1'b1, want0, want1);
          end
          have_first = 1'b0;
          held_first = '0;
          expect_letter(typed_on ? typed_r0 : want0);
          expect_letter(typed_on ? typed_r1 : want1);
        end else begin
          held_first = in_data.letter_code;
          have_first = 1'b1;
        end
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        got = out_data;
        if (pending_letters.size() == 0) begin
          report_mismatch("unexpected result letter", -1, got.out_letter);
        end else begin
          want0 = pending_letters.pop_front();
          if (got.out_letter != want0.out_letter)
            report_mismatch("out_letter", want0.out_letter, got.out_letter);
          if (got.last_out != want0.last_out)
            report_mismatch("last_out", want0.last_out, got.last_out);
          if (got.key_not_invertible != want0.key_not_invertible)
            report_mismatch("key_not_invertible", want0.key_not_invertible,
                            got.key_not_invertible);
        end
      end
      // watchdog
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[hill_cipher_2x2_mod26] ERROR");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (want_hold && !hold_used) begin
      hold_left = LONG_HOLD;
      hold_used = 1'b1;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // offer one letter, with random gaps ahead of it; returns at the falling edge
  // after the transfer with valid still high
  task automatic offer_letter(input logic [4:0] letter, input logic eot);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{letter_code: letter, end_of_text: eot};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop offering, wait for every expected letter, then for the back end
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_letters.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [4:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // key entry biased toward the edges and the out-of-range codes
  function automatic logic [4:0] pick_entry();
    case ($urandom_range(0, 9))
      0:       return 5'd0;
      1:       return 5'd25;
      2:       return 5'($urandom_range(26, 31));
      default: return 5'($urandom_range(0, 25));
    endcase
  endfunction

  task automatic randomize_key();
    write_reg(REG_K00, pick_entry());
    write_reg(REG_K01, pick_entry());
    write_reg(REG_K10, pick_entry());
    write_reg(REG_K11, pick_entry());
    write_reg(REG_DECRYPT, 5'($urandom_range(0, 31)));
    if ($urandom_range(0, 3) == 0)
      write_reg(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 5'($urandom_range(0, 31)));
  endtask

  initial begin
    // kind, letter, eot, index, data, typed, first result, second result
    script = '{
      // reset key: identity, encrypt
      '{ROW_LETTER, 5'd0,  1'b0, REG_K00, 5'd0, 1'b0, NO_RES, NO_RES},
      '{ROW_LETTER, 5'd25, 1'b0, REG_K00, 5'd0, 1'b1, '{5'd0, 1'b0, 1'b0}, '{5'd25, 1'b0, 1'b0}},
      '{ROW_LETTER, 5'd31, 1'b1, REG_K00, 5'd0, 1'b1, '{5'd5, 1'b0, 1'b0}, '{5'd23, 1'b1, 1'b0}},
      '{ROW_LETTER, 5'd26, 1'b0, REG_K00, 5'd0, 1'b0, NO_RES, NO_RES},
      '{ROW_LETTER, 5'd3,  1'b1, REG_K00, 5'd0, 1'b1, '{5'd0, 1'b0, 1'b0}, '{5'd3, 1'b1, 1'b0}},
      // invertible key, encrypt then decrypt
      '{ROW_WRITE,  5'd0,  1'b0, REG_K00, 5'd3, 1'b0, NO_RES, NO_RES},
      '{ROW_WRITE,  5'd0,  1'b0, REG_K01, 5'd3, 1'b0, NO_RES, NO_RES},
      '{ROW_WRITE,  5'd0,  1'b0, REG_K10, 5'd2, 1'b0, NO_RES, NO_RES},
      '{ROW_WRITE,  5'd0,  1'b0, REG_K11, 5'd5, 1'b0, NO_RES, NO_RES},
      '{ROW_LETTER, 5'd7,  1'b0, REG_K00, 5'd0, 1'b0, NO_RES, NO_RES},
      '{ROW_LETTER, 5'd8,  1'b0, REG_K00, 5'd0, 1'b0, NO_RES, NO_RES},
      '{ROW_LETTER, 5'd11, 1'b1, REG_K00, 5'd0, 1'b0, NO_RES, NO_RES},
      '{ROW_WRITE,  5'd0,  1'b0, REG_DECRYPT, 5'd1, 1'b0, NO_RES, NO_RES},
      '{ROW_LETTER, 5'd2,  1'b0, REG_K00, 5'd0, 1'b0, NO_RES, NO_RES},
      '{ROW_LETTER, 5'd19, 1'b1, REG_K00, 5'd0, 1'b0, NO_RES, NO_RES},
      // even determinant in decrypt: error flag, zero letters
      '{ROW_WRITE,  5'd0,  1'b0, REG_K00, 5'd2, 1'b0, NO_RES, NO_RES},
      '{ROW_WRITE,  5'd0,  1'b0, REG_K01, 5'd0, 1'b0, NO_RES, NO_RES},
      '{ROW_WRITE,  5'd0,  1'b0, REG_K10, 5'd0, 1'b0, NO_RES, NO_RES},
      '{ROW_WRITE,  5'd0,  1'b0, REG_K11, 5'd2, 1'b0, NO_RES, NO_RES},
      '{ROW_LETTER, 5'd9,  1'b0, REG_K00, 5'd0, 1'b0, NO_RES, NO_RES},
      '{ROW_LETTER, 5'd4,  1'b1, REG_K00, 5'd0, 1'b1, '{5'd0, 1'b0, 1'b1}, '{5'd0, 1'b1, 1'b1}},
      '{ROW_LETTER, 5'd17, 1'b1, REG_K00, 5'd0, 1'b1, '{5'd0, 1'b0, 1'b1}, '{5'd0, 1'b1, 1'b1}},
      // determinant 13, also without inverse
      '{ROW_WRITE,  5'd0,  1'b0, REG_K00, 5'd13, 1'b0, NO_RES, NO_RES},
      '{ROW_WRITE,  5'd0,  1'b0, REG_K11, 5'd1, 1'b0, NO_RES, NO_RES},
      '{ROW_LETTER, 5'd1,  1'b0, REG_K00, 5'd0, 1'b0, NO_RES, NO_RES},
      '{ROW_LETTER, 5'd1,  1'b1, REG_K00, 5'd0, 1'b1, '{5'd0, 1'b0, 1'b1}, '{5'd0, 1'b1, 1'b1}},
      // out-of-range key codes; mode bit taken from data bit 0
      '{ROW_WRITE,  5'd0,  1'b0, REG_K00, 5'd31, 1'b0, NO_RES, NO_RES},
      '{ROW_WRITE,  5'd0,  1'b0, REG_K01, 5'd31, 1'b0, NO_RES, NO_RES},
      '{ROW_WRITE,  5'd0,  1'b0, REG_K10, 5'd31, 1'b0, NO_RES, NO_RES},
      '{ROW_WRITE,  5'd0,  1'b0, REG_K11, 5'd31, 1'b0, NO_RES, NO_RES},
      '{ROW_WRITE,  5'd0,  1'b0, REG_DECRYPT, 5'd2, 1'b0, NO_RES, NO_RES},
      '{ROW_LETTER, 5'd31, 1'b0, REG_K00, 5'd0, 1'b0, NO_RES, NO_RES},
      '{ROW_LETTER, 5'd30, 1'b1, REG_K00, 5'd0, 1'b0, NO_RES, NO_RES},
      // key and mode change while a first letter is held
      '{ROW_LETTER, 5'd12, 1'b0, REG_K00, 5'd0, 1'b0, NO_RES, NO_RES},
      '{ROW_WRITE,  5'd0,  1'b0, REG_DECRYPT, 5'd31, 1'b0, NO_RES, NO_RES},
      '{ROW_WRITE,  5'd0,  1'b0, REG_K01, 5'd0, 1'b0, NO_RES, NO_RES},
      '{ROW_WRITE,  5'd0,  1'b0, REG_K10, 5'd0, 1'b0, NO_RES, NO_RES},
      '{ROW_LETTER, 5'd0,  1'b1, REG_K00, 5'd0, 1'b0, NO_RES, NO_RES},
      // undecoded indexes change nothing
      '{ROW_WRITE,  5'd0,  1'b0, REG_UNUSED_LO, 5'd31, 1'b0, NO_RES, NO_RES},
      '{ROW_WRITE,  5'd0,  1'b0, REG_UNUSED_HI, 5'd0, 1'b0, NO_RES, NO_RES},
      '{ROW_LETTER, 5'd25, 1'b0, REG_K00, 5'd0, 1'b0, NO_RES, NO_RES},
      '{ROW_LETTER, 5'd26, 1'b1, REG_K00, 5'd0, 1'b0, NO_RES, NO_RES}
    };

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed script
    foreach (script[n]) begin
      if (script[n].kind == ROW_WRITE) begin
        settle_block();
        write_reg(script[n].idx, script[n].val);
      end else begin
        typed_on = script[n].typed;
        typed_r0 = script[n].r0;
        typed_r1 = script[n].r1;
        offer_letter(script[n].letter, script[n].eot);
        typed_on = 1'b0;
      end
    end

    // random messages under changing keys; idle pattern per pass
    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int chunk = 0; chunk < 5; chunk++) begin
        settle_block();
        randomize_key();
        if (pass == 2 && chunk == 1) want_hold = 1'b1;
        for (int k = 0; k < CHUNK_LETTERS; k++) begin
          offer_letter(($urandom_range(0, 7) == 0) ? 5'($urandom_range(26, 31))
                                                   : 5'($urandom_range(0, 25)),
                       $urandom_range(0, 7) == 0);
        end
      end
    end

    settle_block();
    if (error_count == 0) begin
      $display("[hill_cipher_2x2_mod26] OK");
    end else begin
      $display("[hill_cipher_2x2_mod26] ERROR");
    end
    $finish;
  end

endmodule
